FILE: sv/assert_macros.svh
// Assertion macros shared by the load cell scale RTL.
// No dependencies; include by bare file name after the module ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/lcts_pkg.sv
// Package for the load cell tare/calibrate/scale block: item types, codes, widths.
// No dependencies.
`timescale 1ns / 1ps

package lcts_pkg;

  localparam int SAMPLE_W = 24;
  localparam int MASS_W   = 16;
  localparam int WEIGHT_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int OP_W     = 2;

  localparam logic [MASS_W-1:0] MASS_RESET = 16'd1000;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TARE    = 2'd0;
  localparam logic [OP_W-1:0] OP_CAL     = 2'd1;
  localparam logic [OP_W-1:0] OP_MEASURE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SPAN_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RUN      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd3;

  // Saturation limits as magnitudes
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN_MAG = 32'h8000_0000;

  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic signed [SAMPLE_W-1:0] sample;
  } req_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         run_count;
  } rsp_t;

endpackage

FILE: sv/lcts_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle (unsigned).
// No package dependencies.
`timescale 1ns / 1ps

module lcts_mul #(
  parameter int AW = 26,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] product
);

  localparam int CW = $clog2(BW + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     mcand;
  logic [AW+BW:0]    p;
  logic [AW:0]       acc_hi;

  // Add the multiplicand into the upper half when the current bit is set.
  assign acc_hi  = p[AW+BW:BW] + (p[0] ? {1'b0, mcand} : '0);
  assign product = p[AW+BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      p     <= {{(AW+1){1'b0}}, b};
    end else if (busy) begin
      p <= {1'b0, acc_hi, p[BW-1:1]};
    end
  end

endmodule

FILE: sv/lcts_div.sv
// Bit-serial restoring divider, one quotient bit per cycle (unsigned).
// No package dependencies; divisor must be nonzero.
`timescale 1ns / 1ps

module lcts_div #(
  parameter int NW = 44,
  parameter int DW = 26
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic          fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, quotient[NW-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      quotient <= {quotient[NW-2:0], fits};
    end
  end

endmodule

FILE: sv/load_cell_tare_calibrate_scale_core.sv
// Load cell tare, span calibration and weighing; uses lcts_pkg, lcts_mul, lcts_div.
// Path from accept to result valid: a mid-run tare/calibrate item or a zero-span measure
// goes straight to S_WR; a run's last item runs a serial divide by the run length (S_DIV);
// a measure item runs a serial multiply (S_MUL), then a serial divide (S_DIV), then S_WR.
// One item in flight; the next is accepted in the cycle after its result registers.
// Reset (rst, synchronous): zero point, span and run clear, reference mass goes to 1000.
`timescale 1ns / 1ps

module load_cell_tare_calibrate_scale_core #(
  parameter int SAMPLES_PER_AVERAGE = 20,
  parameter int SAMPLE_BITS         = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  // sample channel
  input  logic                        req_valid,
  output logic                        req_stall,
  input  lcts_pkg::req_t              req,
  // result channel
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output lcts_pkg::rsp_t              rsp,
  // reference mass register write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lcts_pkg::MASS_W-1:0] cfg_data
);

  import lcts_pkg::*;

  // Internal widths: sample/zero point, span and difference, run sum, quotient.
  localparam int SW  = SAMPLE_BITS + 1;
  localparam int SPW = SW + 1;
  localparam int RW  = SW + 6;
  localparam int QW  = SPW + MASS_W;
  localparam int EW  = (QW > WEIGHT_W + 1) ? QW : WEIGHT_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0]             state;

  // Architectural state
  logic [MASS_W-1:0]      ref_mass;
  logic signed [SW-1:0]   zero_point;
  logic signed [SPW-1:0]  span;
  logic signed [RW-1:0]   run_sum;
  logic [COUNT_W-1:0]     run_samples;
  logic                   run_kind;

  // Job bookkeeping while the serial units run
  rsp_t                   res;
  logic                   job_avg;
  logic                   job_cal;
  logic                   sum_neg;
  logic                   q_neg;

  // Accept-side decode
  logic                   acc;
  logic                   is_run;
  logic                   run_is_cal;
  logic                   restart;
  logic [31:0]            raw32;
  logic signed [SW-1:0]   s_ext;
  logic signed [RW-1:0]   base_sum;
  logic [COUNT_W-1:0]     base_cnt;
  logic signed [RW-1:0]   new_sum;
  logic [COUNT_W-1:0]     new_cnt;
  logic                   finish;
  logic [RW-1:0]          sum_mag;
  logic signed [SPW-1:0]  diff;
  logic [SPW-1:0]         diff_mag;
  logic [SPW-1:0]         span_mag;
  logic                   span_zero;

  // Serial units
  logic                   mul_start;
  logic                   mul_done;
  logic [QW-1:0]          mul_prod;
  logic                   div_start;
  logic                   div_done;
  logic [QW-1:0]          div_dividend;
  logic [SPW-1:0]         div_divisor;
  logic [QW-1:0]          div_q;

  // Result shaping
  logic [SW-1:0]          avg_mag;
  logic signed [SW-1:0]   avg;
  logic [EW-1:0]          q_ext;
  logic signed [WEIGHT_W-1:0] sat_weight;
  logic                   rsp_free;

  // The user writes configuration only while idle; the block takes it whenever out of reset.
  assign cfg_ready = !rst;

  // Hold off new items in reset and until the current one has its result registered.
  assign req_stall = rst || (state != S_IDLE);
  assign acc       = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Op three falls through to measure.
  assign is_run     = (req.op == OP_TARE) || (req.op == OP_CAL);
  assign run_is_cal = (req.op == OP_CAL);

  // Sign-extend the converter reading from SAMPLE_BITS bits.
  assign raw32 = {{(32-SAMPLE_W){1'b0}}, req.sample};
  assign s_ext = {raw32[SAMPLE_BITS-1], raw32[SAMPLE_BITS-1:0]};

  // Drop a partial run of the other kind and start over with this item.
  assign restart  = (run_samples == '0) || (run_kind != run_is_cal);
  assign base_sum = restart ? '0 : run_sum;
  assign base_cnt = restart ? '0 : run_samples;
  assign new_sum  = base_sum + RW'(s_ext);
  assign new_cnt  = base_cnt + 1'b1;
  assign finish   = (new_cnt >= COUNT_W'(SAMPLES_PER_AVERAGE));
  assign sum_mag  = new_sum[RW-1] ? $unsigned(-new_sum) : $unsigned(new_sum);

  // Measure operands: magnitude of (zero - sample) and of span.
  assign diff      = SPW'(zero_point) - SPW'(s_ext);
  assign diff_mag  = diff[SPW-1] ? $unsigned(-diff) : $unsigned(diff);
  assign span_mag  = span[SPW-1] ? $unsigned(-span) : $unsigned(span);
  assign span_zero = (span == '0);

  assign mul_start = (state == S_IDLE) && acc && !is_run && !span_zero;

  // One divider serves both the run average and the weight quotient.
  assign div_start    = ((state == S_IDLE) && acc && is_run && finish) ||
                        ((state == S_MUL) && mul_done);
  assign div_dividend = (state == S_MUL) ? mul_prod : QW'(sum_mag);
  assign div_divisor  = (state == S_MUL) ? span_mag : SPW'(SAMPLES_PER_AVERAGE);

  lcts_mul #(
    .AW (SPW),
    .BW (MASS_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (diff_mag),
    .b       (ref_mass),
    .done    (mul_done),
    .product (mul_prod)
  );

  lcts_div #(
    .NW (QW),
    .DW (SPW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Truncating average: restore the sign of the run sum.
  assign avg_mag = div_q[SW-1:0];
  assign avg     = sum_neg ? -$signed(avg_mag) : $signed(avg_mag);

  // Saturate the quotient to signed 32 bits, then restore its sign.
  assign q_ext = EW'(div_q);
  always_comb begin
    priority if (!q_neg && (q_ext > EW'(WEIGHT_MAX))) begin
      sat_weight = $signed(WEIGHT_MAX);
    end else if (q_neg && (q_ext > EW'(WEIGHT_MIN_MAG))) begin
      sat_weight = $signed(WEIGHT_MIN_MAG);
    end else if (q_neg) begin
      sat_weight = $signed(WEIGHT_W'(0) - q_ext[WEIGHT_W-1:0]);
    end else begin
      sat_weight = $signed(q_ext[WEIGHT_W-1:0]);
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      ref_mass    <= MASS_RESET;
      zero_point  <= '0;
      span        <= '0;
      run_sum     <= '0;
      run_samples <= '0;
      run_kind    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ref_mass <= cfg_data;
      end
      // Present a new result, or drop the one just taken.
      if ((state == S_WR) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (is_run) begin
              run_kind <= run_is_cal;
              if (finish) begin
                // Clear the run now; the average lands when the divide ends.
                run_sum     <= '0;
                run_samples <= '0;
                state       <= S_DIV;
              end else begin
                run_sum     <= new_sum;
                run_samples <= new_cnt;
                state       <= S_WR;
              end
            end else begin
              // A measurement discards any partial run.
              run_sum     <= '0;
              run_samples <= '0;
              state       <= span_zero ? S_WR : S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (job_avg) begin
              if (job_cal) begin
                span <= SPW'(zero_point) - SPW'(avg);
              end else begin
                zero_point <= avg;
              end
            end
            state <= S_WR;
          end
        end
        S_WR: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Result and job payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && acc) begin
      res.weight <= '0;
      if (is_run) begin
        res.status    <= finish ? ST_DONE : ST_RUN;
        res.run_count <= new_cnt;
        job_avg       <= 1'b1;
        job_cal       <= run_is_cal;
        sum_neg       <= new_sum[RW-1];
      end else begin
        res.status    <= span_zero ? ST_SPAN_ERR : ST_OK;
        res.run_count <= '0;
        job_avg       <= 1'b0;
        q_neg         <= diff[SPW-1] ^ span[SPW-1];
      end
    end
    if ((state == S_DIV) && div_done && !job_avg) begin
      res.weight <= sat_weight;
    end
    if ((state == S_WR) && rsp_free) begin
      rsp <= res;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_err_weight_zero, clk, rst,
                rsp_valid && (rsp.status != ST_OK), rsp.weight == '0)
  `ASSERT_ALWAYS(a_run_bound, clk, rst, run_samples < COUNT_W'(SAMPLES_PER_AVERAGE))
  `ASSERT_NEXT(a_measure_drops_run, clk, rst, acc && !is_run, run_samples == '0)
  `ASSERT_IMPLY(a_run_count_mid, clk, rst, rsp_valid && (rsp.status == ST_RUN),
                (rsp.run_count != '0) && (rsp.run_count < COUNT_W'(SAMPLES_PER_AVERAGE)))
  `ASSERT_IMPLY(a_run_count_done, clk, rst, rsp_valid && (rsp.status == ST_DONE),
                rsp.run_count == COUNT_W'(SAMPLES_PER_AVERAGE))

endmodule

FILE: tb/load_cell_tare_calibrate_scale_core_tb.sv
// Testbench for load_cell_tare_calibrate_scale_core: directed and random sample items,
// checked against an in-bench scale model with tare zero, span and averaging run state.
// Depends on lcts_pkg and the core RTL only.
`timescale 1ns / 1ps

module load_cell_tare_calibrate_scale_core_tb;
  import lcts_pkg::*;

  // Op code 3 is not named in the package; the block treats it as a measure.
  localparam logic [OP_W-1:0] OP_MEASURE_ALT = 2'd3;

  localparam int  RUN_LENGTH   = 20;    // samples per tare/calibrate average
  localparam int  HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int  QUIET_LIMIT  = 4000;  // cycles without any handshake before giving up
  localparam int  DRAIN_CYCLES = 100;   // settle time after the last result
  localparam int  SAMPLE_MAX   = 8388607;
  localparam int  SAMPLE_MIN   = -8388608;
  localparam longint WEIGHT_HI = 64'sd2147483647;
  localparam longint WEIGHT_LO = -64'sd2147483648;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req       = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [MASS_W-1:0] cfg_data  = '0;

  // Scale model state, kept in step with every accepted item and register write.
  longint            tare_zero;
  longint            span_counts;
  longint            run_total;
  int                run_len;
  logic [OP_W-1:0]   run_op;
  logic [MASS_W-1:0] ref_mass;

  rsp_t expected_readings[$];
  int   items_sent;
  int   errors;
  int   send_gap_pct;
  int   stall_pct;
  bit   hold_req;

  load_cell_tare_calibrate_scale_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scale model: advance the averaging run or weigh one sample, return the reading.
  // ---------------------------------------------------------------------------
  function automatic rsp_t predict_reading(req_t item);
    longint s;
    longint avg;
    longint q;
    rsp_t   r;
    s = longint'($signed(item.sample));
    r = '0;
    if (item.op == OP_TARE || item.op == OP_CAL) begin
      // A sample of the other run kind, or the first after a finish, restarts the run.
      if (run_len == 0 || run_op != item.op) begin
        run_total = 0;
        run_len   = 0;
        run_op    = item.op;
      end
      run_total += s;
      run_len++;
      r.run_count = run_len[COUNT_W-1:0];
      if (run_len >= RUN_LENGTH) begin
        avg = run_total / longint'(RUN_LENGTH);  // truncates toward zero
        if (item.op == OP_TARE) tare_zero = avg;
        else span_counts = tare_zero - avg;
        r.status  = ST_DONE;
        run_total = 0;
        run_len   = 0;
      end else begin
        r.status = ST_RUN;
      end
    end else begin
      // Any measure (op 2 or 3) drops a partial run.
      run_total = 0;
      run_len   = 0;
      if (span_counts == 0) begin
        r.status = ST_SPAN_ERR;
      end else begin
        q = ((tare_zero - s) * longint'(ref_mass)) / span_counts;
        if (q > WEIGHT_HI) q = WEIGHT_HI;
        if (q < WEIGHT_LO) q = WEIGHT_LO;
        r.weight = q[WEIGHT_W-1:0];
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  function automatic int any_sample();
    return int'($urandom_range(24'hFF_FFFF)) + SAMPLE_MIN;
  endfunction

  function automatic int clamp_sample(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return int'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: idle at random, offer one item, hold it until accepted, then predict.
  // Called just after a rising edge; returns just after the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [OP_W-1:0] op, input int value);
    req_t item;
    item.op     = op;
    item.sample = value[SAMPLE_W-1:0];
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!(req_valid && !req_stall));
    expected_readings.push_back(predict_reading(item));
    items_sent++;
  endtask

  // Drop valid and wait until every expected reading has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
  endtask

  // Write the reference mass while the block is idle.
  task automatic write_mass(input logic [MASS_W-1:0] mass);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= mass;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    ref_mass = mass;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall at random, or hold off for a long stretch when asked.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_stall <= 1'b1;
        for (int i = 1; i < HOLD_CYCLES; i++) @(posedge clk);
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic void flag_field(string field, longint want, longint got);
    errors++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endfunction

  // Compare each accepted reading with the oldest expectation, field by field.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: reading with none expected, expected none actual %0d/%0d/%0d",
                 $time, rsp.weight, rsp.status, rsp.run_count);
      end else begin
        want = expected_readings.pop_front();
        if (rsp.weight !== want.weight) flag_field("weight", want.weight, rsp.weight);
        if (rsp.status !== want.status) flag_field("status", want.status, rsp.status);
        if (rsp.run_count !== want.run_count)
          flag_field("run_count", want.run_count, rsp.run_count);
      end
    end
  end

  // Give up when no channel has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Span is zero out of reset: measures flag the error, op 3 acts as a measure.
  task automatic test_span_error();
    send_sample(OP_MEASURE, 0);
    send_sample(OP_MEASURE_ALT, SAMPLE_MIN);
  endtask

  // A calibrate item interrupts a tare run; a measure drops the partial run.
  task automatic test_interrupted_runs();
    send_sample(OP_TARE, SAMPLE_MAX);
    send_sample(OP_CAL, SAMPLE_MIN);
    send_sample(OP_MEASURE, 0);
  endtask

  // Calibrate to a span of one count, then weigh the extremes to hit both saturation limits.
  task automatic test_saturation();
    repeat (RUN_LENGTH) send_sample(OP_CAL, -1);
    send_sample(OP_MEASURE, SAMPLE_MIN);
    send_sample(OP_MEASURE_ALT, SAMPLE_MAX);
  endtask

  // A zero reference mass weighs everything as 0 with a valid status.
  task automatic test_zero_mass();
    write_mass('0);
    send_sample(OP_MEASURE, 12345);
    write_mass(MASS_W'($urandom_range(65535)));
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly complete runs and measure bursts, some broken sequences.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input int count);
    int              target;
    int              pick;
    int              base;
    int              spread;
    int              n;
    logic [OP_W-1:0] op;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // Full tare run around some level.
        case ($urandom_range(3))
          0: base = any_sample();
          1: base = SAMPLE_MAX - int'($urandom_range(1000));
          2: base = SAMPLE_MIN + int'($urandom_range(1000));
          default: base = int'($urandom_range(2000)) - 1000;
        endcase
        case ($urandom_range(2))
          0: spread = 0;
          1: spread = $urandom_range(100);
          default: spread = $urandom_range(100000);
        endcase
        repeat (RUN_LENGTH)
          send_sample(OP_TARE, clamp_sample(base + int'($urandom_range(2 * spread)) - spread));
      end else if (pick < 55) begin
        // Full calibrate run; small offsets from zero give zero or tiny spans.
        case ($urandom_range(4))
          0: begin base = clamp_sample(tare_zero); spread = 0; end
          1: begin base = clamp_sample(tare_zero + int'($urandom_range(6)) - 3); spread = 0; end
          2: begin
            base   = clamp_sample(tare_zero + int'($urandom_range(2000)) - 1000);
            spread = 10;
          end
          3: begin
            base   = clamp_sample(tare_zero + int'($urandom_range(4000000)) - 2000000);
            spread = 1000;
          end
          default: begin base = any_sample(); spread = $urandom_range(1000000); end
        endcase
        repeat (RUN_LENGTH)
          send_sample(OP_CAL, clamp_sample(base + int'($urandom_range(2 * spread)) - spread));
      end else if (pick < 85) begin
        // Burst of measures, near the zero point or anywhere.
        n = $urandom_range(6, 1);
        repeat (n) begin
          op = $urandom_range(1) ? OP_MEASURE : OP_MEASURE_ALT;
          if ($urandom_range(1))
            send_sample(op, clamp_sample(tare_zero + int'($urandom_range(10000)) - 5000));
          else
            send_sample(op, any_sample());
        end
      end else begin
        // Noise: mostly repeat the op, sometimes switch, to break runs part way.
        n  = $urandom_range(25, 1);
        op = OP_W'($urandom_range(3));
        repeat (n) begin
          if ($urandom_range(4) == 0) op = OP_W'($urandom_range(3));
          send_sample(op, any_sample());
        end
      end
    end
  endtask

  // Hold the receiver off while items keep coming, then let the sender wait for the backlog.
  task automatic test_output_backlog();
    hold_req = 1'b1;
    repeat (12) send_sample($urandom_range(1) ? OP_MEASURE : OP_TARE, any_sample());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    tare_zero   = 0;
    span_counts = 0;
    run_total   = 0;
    run_len     = 0;
    run_op      = OP_TARE;
    ref_mass    = MASS_RESET;
    items_sent  = 0;
    errors      = 0;
    hold_req    = 1'b0;
    // Sender idles with a 29 percent chance per try, receiver stalls with 49.
    send_gap_pct = 29;
    stall_pct    = 49;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_span_error();
    test_interrupted_runs();
    test_saturation();
    test_zero_mass();
    test_random_traffic(450);

    // Swap the idle rates; smallest mass.
    write_mass(16'd1);
    send_gap_pct = 49;
    stall_pct    = 29;
    test_random_traffic(450);
    test_output_backlog();

    // No idling; largest mass, then the reset value.
    write_mass(16'hFFFF);
    send_gap_pct = 0;
    stall_pct    = 0;
    test_random_traffic(300);
    write_mass(MASS_RESET);
    test_random_traffic(150);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/lcts_pkg.sv
sv/lcts_mul.sv
sv/lcts_div.sv
sv/load_cell_tare_calibrate_scale_core.sv
tb/load_cell_tare_calibrate_scale_core_tb.sv
